// ===== hdl/hhfv_pkg.sv =====
package hhfv_pkg;

	// Result codes carried on the status field.
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_ACCEPT     = 3'd1,
		ST_EMPTY_NAME = 3'd2,
		ST_BAD_NAME   = 3'd3,
		ST_BAD_CTRL   = 3'd4,
		ST_BAD_CRLF   = 3'd5
	} status_t;

	// Position within a CR/LF folding sequence of the value.
	typedef enum logic [1:0] {
		FOLD_IDLE     = 2'd0,
		FOLD_AFTER_CR = 2'd1,
		FOLD_AFTER_LF = 2'd2
	} fold_t;

	// Item type codes.
	localparam logic REQ_NAME  = 1'b0;
	localparam logic REQ_VALUE = 1'b1;

	// Byte constants used by the checks.
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DEL   = 8'h7F;

	// One input word.
	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic       no_byte;
		logic       last_of_part;
	} hhfv_item_t;

	// Header state carried between words.
	typedef struct packed {
		fold_t      fold_state;
		status_t    first_error;
		logic       name_has_byte;
	} hhfv_state_t;

	// One result word.
	typedef struct packed {
		status_t status;
		logic    done_res;
	} hhfv_result_t;

	localparam hhfv_state_t STATE_RESET = '{
		fold_state:    FOLD_IDLE,
		first_error:   ST_OK,
		name_has_byte: 1'b0
	};

	// True for an HTTP token character: digit, letter or one of the listed symbols.
	function automatic logic is_token_byte(input logic [7:0] c);
		logic hit;
		hit = ((c >= 8'h30) && (c <= 8'h39)) ||
		      ((c >= 8'h41) && (c <= 8'h5A)) ||
		      ((c >= 8'h61) && (c <= 8'h7A));
		case (c)
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
			8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: hit = 1'b1;
			default: ;
		endcase
		return hit;
	endfunction

endpackage

// ===== hdl/hhfv_step.sv =====
module hhfv_step
	import hhfv_pkg::*;
(
	input  hhfv_item_t   item,
	input  hhfv_state_t  cur,
	output hhfv_state_t  nxt,
	output hhfv_result_t result
);

	status_t err_name;
	status_t err_value;
	fold_t   fold_value;
	logic    has_byte;

	// Name words: note a byte, then check the byte and the end of an empty name.
	always_comb begin
		has_byte = cur.name_has_byte | ~item.no_byte;
		err_name = cur.first_error;
		if (!item.no_byte && !is_token_byte(item.data_byte) && err_name == ST_OK) begin
			err_name = ST_BAD_NAME;
		end
		if (item.last_of_part && !has_byte && err_name == ST_OK) begin
			err_name = ST_EMPTY_NAME;
		end
	end

	// Value words: folding checker, frozen once an error is latched.
	always_comb begin
		fold_value = cur.fold_state;
		err_value  = cur.first_error;
		if (!item.no_byte && cur.first_error == ST_OK) begin
			case (cur.fold_state)
				FOLD_AFTER_CR: begin
					if (item.data_byte == CHAR_LF) fold_value = FOLD_AFTER_LF;
					else err_value = ST_BAD_CRLF;
				end
				FOLD_AFTER_LF: begin
					if (item.data_byte == CHAR_SPACE || item.data_byte == CHAR_TAB) begin
						fold_value = FOLD_IDLE;
					end else begin
						err_value = ST_BAD_CTRL;
					end
				end
				default: begin
					if (item.data_byte == CHAR_CR) begin
						fold_value = FOLD_AFTER_CR;
					end else if (item.data_byte == CHAR_LF) begin
						fold_value = FOLD_AFTER_LF;
					end else if (item.data_byte == CHAR_DEL ||
					             (item.data_byte < CHAR_SPACE && item.data_byte != CHAR_TAB)) begin
						err_value = ST_BAD_CTRL;
					end else begin
						fold_value = FOLD_IDLE;
					end
				end
			endcase
		end
	end

	// Select the result and the state left behind; the final value word clears it.
	always_comb begin
		nxt    = cur;
		result = '{status: ST_OK, done_res: 1'b0};
		if (item.req_type == REQ_NAME) begin
			nxt.name_has_byte = has_byte;
			nxt.first_error   = err_name;
			result.status     = err_name;
		end else if (!item.last_of_part) begin
			nxt.fold_state  = fold_value;
			nxt.first_error = err_value;
			result.status   = err_value;
		end else begin
			nxt             = STATE_RESET;
			result.done_res = 1'b1;
			if (!cur.name_has_byte) result.status = ST_EMPTY_NAME;
			else if (err_value != ST_OK) result.status = err_value;
			else if (fold_value == FOLD_AFTER_CR || fold_value == FOLD_AFTER_LF) begin
				result.status = ST_BAD_CRLF;
			end else begin
				result.status = ST_ACCEPT;
			end
		end
	end

endmodule

// ===== hdl/http_header_field_validator.sv =====
// An accepted word waits in the input register; its result is shown from the output register.
// Throughput: one word per cycle; the input register, the step logic and the output register
// form a two-stage pipeline that advances whenever the output register is free or taken.
// Reset: arst_n low clears both stage valid flags and the header state at once.
// A result left waiting on out_ready holds the pipeline, and input is taken while it waits
// only when the input register is empty.
module http_header_field_validator
	import hhfv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] data_byte,
	input  logic       no_byte,
	input  logic       last_of_part,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic       done_res
);

	hhfv_item_t   item_s1;
	logic         valid_s1;
	hhfv_result_t result_s2;
	logic         valid_s2;
	hhfv_state_t  state_q;
	hhfv_state_t  state_nxt;
	hhfv_result_t result_nxt;
	logic         move_s1;
	logic         s2_free;

	// Pipeline flow control.
	assign s2_free  = ~valid_s2 | out_ready;
	assign move_s1  = valid_s1 & s2_free;
	assign in_ready = ~valid_s1 | move_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{req_type: req_type, data_byte: data_byte,
			             no_byte: no_byte, last_of_part: last_of_part};
		end
	end

	// Per-word check and state update.
	hhfv_step u_step (
		.item   (item_s1),
		.cur    (state_q),
		.nxt    (state_nxt),
		.result (result_nxt)
	);

	// Header state advances as each word leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (move_s1) begin
			state_q <= state_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			result_s2 <= result_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign status    = result_s2.status;
	assign done_res  = result_s2.done_res;

endmodule

// ===== hdl/hhfv_checker.sv =====
module hhfv_checker
	import hhfv_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic       done_res
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(done_res))
		else $error("result word changed while stalled");

	// A final verdict is never the running code for no error.
	a_final_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> status != ST_OK)
		else $error("final verdict reads as no error");

	// Acceptance is reported only on the final word.
	a_accept_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ACCEPT |-> done_res)
		else $error("accepted status on a word that is not final");

	// Status stays within the defined codes.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_BAD_CRLF)
		else $error("status outside the defined codes");

	// With the output free, the block can always take a word.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output stage is empty");

endmodule

bind http_header_field_validator hhfv_checker u_hhfv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.done_res  (done_res)
);
